/* hdl/bkv_pkg.sv */
// ----------------------------------------------------------------------------
// bkv_pkg: shared definitions for the bucketed key/value table
// Field widths, operation and status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package bkv_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 64;
    localparam int ST_W   = 2;
    localparam int CFG_W  = 7;
    localparam int STEP_W = $clog2(KEY_W + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd8;

    localparam int MAX_BUCKETS_DEF = 64;
    localparam int WAYS_DEF        = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_UPD
    } t_state;

    // address width for a store of the given depth, never below one bit
    function automatic int addr_w(input int depth);
        int w;
        w = (depth > 1) ? $clog2(depth) : 1;
        return w;
    endfunction

endpackage

/* hdl/bkv_req_if.sv */
// ----------------------------------------------------------------------------
// bkv_req_if: request channel
// Valid/ready channel carrying one operation, its key and its value.
// ----------------------------------------------------------------------------
interface bkv_req_if;
    import bkv_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);

endinterface

/* hdl/bkv_rsp_if.sv */
// ----------------------------------------------------------------------------
// bkv_rsp_if: response channel
// Valid/ready channel carrying the status and data of one operation.
// ----------------------------------------------------------------------------
interface bkv_rsp_if;
    import bkv_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);

endinterface

/* hdl/bucketed_key_value_table.sv */
// ----------------------------------------------------------------------------
// bucketed_key_value_table: key to 64-bit value map in fixed-way buckets
// Insert/replace, delete and lookup over MAX_BUCKETS x WAYS entries.
// ----------------------------------------------------------------------------
// One transaction at a time. After an accepted request the key is reduced
// modulo the bucket count by a bit-serial remainder unit (one key bit per
// step, then the remainder is handed over). Then the bucket's ways are read
// one by one from the key and value RAMs, each way read, then compared,
// stopping early on a key match. A final update step applies the update and
// loads the response register. The block is ready for the next request in
// the cycle after that update. The response register lets a new request in
// while the previous response still waits; the update cycle of that new
// request stalls until the register has drained. After reset the valid bits
// held in the key RAM are cleared one entry per cycle, all MAX_BUCKETS*WAYS
// entries (256 by default), during which no request is accepted; bucket_count
// writes are taken at any time but must only be made while the block is
// idle.
// ----------------------------------------------------------------------------
module bucketed_key_value_table #(
    parameter int MAX_BUCKETS = bkv_pkg::MAX_BUCKETS_DEF,
    parameter int WAYS        = bkv_pkg::WAYS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bkv_pkg::CFG_W-1:0] i_cfg_wdata,
    bkv_req_if.sink                  i_req,
    bkv_rsp_if.source                o_rsp
);
    import bkv_pkg::*;

    localparam int ENTRIES = MAX_BUCKETS * WAYS;
    localparam int ADDR_W  = addr_w(ENTRIES);
    localparam int WAY_W   = addr_w(WAYS);
    localparam int DIV_W   = $clog2(MAX_BUCKETS + 1);
    localparam int CMP_W   = (DIV_W > CFG_W) ? DIV_W : CFG_W;

    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(ENTRIES - 1);
    localparam logic [WAY_W-1:0]  LAST_WAY   = WAY_W'(WAYS - 1);

    // sequencer and working registers
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_bucket_count;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [OP_W-1:0]   r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [WAY_W-1:0]  r_way, n_way;
    logic [WAY_W-1:0]  r_tgt_way, n_tgt_way;
    logic              r_hit, n_hit;
    logic              r_free, n_free;
    logic [VAL_W-1:0]  r_found, n_found;

    // response register
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_out_status, n_out_status;
    logic [VAL_W-1:0]  r_out_value, n_out_value;

    // key RAM holds {valid, key}; value RAM holds the data
    logic              key_we;
    logic [ADDR_W-1:0] key_waddr;
    logic [KEY_W:0]    key_wdata;
    logic [KEY_W:0]    key_rdata;
    logic              val_we;
    logic [VAL_W-1:0]  val_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] tgt_addr;

    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_rem;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  eff_buckets;
    logic              out_free;
    logic              match;

    // bucket count clamped to 1..MAX_BUCKETS
    assign cnt_ext     = CMP_W'(r_bucket_count);
    assign eff_buckets = (cnt_ext == '0) ? CMP_W'(1) :
                         (cnt_ext > CMP_W'(MAX_BUCKETS)) ? CMP_W'(MAX_BUCKETS) : cnt_ext;

    bkv_mod_unit #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_key     (i_req.key),
        .i_divisor (eff_buckets[DIV_W-1:0]),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    assign rd_addr  = r_base + ADDR_W'(r_way);
    assign tgt_addr = r_base + ADDR_W'(r_tgt_way);

    bkv_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    bkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (tgt_addr),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    assign out_free = !r_out_valid || o_rsp.ready;
    assign match    = key_rdata[KEY_W] && (key_rdata[KEY_W-1:0] == r_key);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_base       = r_base;
        n_way        = r_way;
        n_tgt_way    = r_tgt_way;
        n_hit        = r_hit;
        n_free       = r_free;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        key_we       = 1'b0;
        key_waddr    = r_clr_addr;
        key_wdata    = '0;
        val_we       = 1'b0;
        div_start    = 1'b0;
        i_req.ready  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // wipe valid bits, one entry a cycle
                key_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op      = i_req.op;
                    n_key     = i_req.key;
                    n_value   = i_req.value;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_base  = ADDR_W'(div_rem * WAYS);
                    n_way   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (match) begin
                    n_hit     = 1'b1;
                    n_tgt_way = r_way;
                    n_found   = val_rdata;
                    n_state   = S_UPD;
                end else begin
                    // remember the lowest free way for an insert
                    if (!key_rdata[KEY_W] && !r_free) begin
                        n_free    = 1'b1;
                        n_tgt_way = r_way;
                    end
                    if (r_way == LAST_WAY) begin
                        n_state = S_UPD;
                    end else begin
                        n_way   = r_way + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_UPD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ABSENT;
                    n_out_value  = '0;
                    n_state      = S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            if (r_hit) begin
                                val_we       = 1'b1;
                                n_out_status = ST_DONE;
                            end else if (r_free) begin
                                key_we       = 1'b1;
                                key_waddr    = tgt_addr;
                                key_wdata    = {1'b1, r_key};
                                val_we       = 1'b1;
                                n_out_status = ST_DONE;
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            if (r_hit) begin
                                key_we       = 1'b1;
                                key_waddr    = tgt_addr;
                                key_wdata    = {1'b0, r_key};
                                n_out_status = ST_DONE;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_hit) begin
                                n_out_status = ST_DONE;
                                n_out_value  = r_found;
                            end
                        end
                        default: begin
                            // unused code: no operation, reported as absent
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_bucket_count <= CFG_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_base       <= n_base;
        r_way        <= n_way;
        r_tgt_way    <= n_tgt_way;
        r_hit        <= n_hit;
        r_free       <= n_free;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_value;

`ifndef ASSERT_OFF
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_req.ready)
        else $error("request taken before the valid bits were cleared");

    a_miss_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_DONE) |-> o_rsp.found_value == '0)
        else $error("data returned with a miss or full status");

    a_accept_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state == S_DIV)
        else $error("accepted transaction did not start the modulo");

    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> r_way <= LAST_WAY)
        else $error("way scan ran past the bucket");
`endif

endmodule

/* hdl/bkv_ram.sv */
// ----------------------------------------------------------------------------
// bkv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bkv_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = bkv_pkg::addr_w(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bkv_mod_unit.sv */
// ----------------------------------------------------------------------------
// bkv_mod_unit: iterative key modulo bucket count
// Restoring remainder, one key bit per cycle through one compare-subtract.
// ----------------------------------------------------------------------------
module bkv_mod_unit #(
    parameter int MAX_BUCKETS = bkv_pkg::MAX_BUCKETS_DEF,
    localparam int DIV_W = $clog2(MAX_BUCKETS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [bkv_pkg::KEY_W-1:0] i_key,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [DIV_W-1:0]        o_rem
);
    import bkv_pkg::*;

    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_shift, n_shift;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic              r_done, n_done;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;

    // partial remainder stays below the divisor, so one extra bit covers the shift
    assign trial = {r_rem, r_shift[KEY_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = trial >= {1'b0, i_divisor};

    always_comb begin
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_done  = 1'b0;
        if (i_start) begin
            n_cnt   = STEP_W'(KEY_W);
            n_shift = i_key;
            n_rem   = '0;
        end else if (r_cnt != '0) begin
            n_cnt   = r_cnt - 1'b1;
            n_shift = {r_shift[KEY_W-2:0], 1'b0};
            n_rem   = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            n_done  = (r_cnt == STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_cnt == '0)
        else $error("modulo started while busy");

    a_done_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_cnt) == STEP_W'(1))
        else $error("modulo done without finishing its steps");
`endif

endmodule
